// File: hw/rtl/sqlkw_pkg.sv
// ----------------------------------------------------------------------------
// sqlkw_pkg
// Shared types, constants and character-class helpers for the statement
// keyword scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sqlkw_pkg;

    localparam int WINDOW_DEPTH = 11;
    localparam int KW_COUNT     = 14;
    localparam int KW_MAXLEN    = 10;
    localparam int KW_BITS      = 8 * KW_MAXLEN;
    localparam int KW_LEN_W     = $clog2(KW_MAXLEN + 1);
    localparam int COUNT_W      = 17;
    localparam int LEN_W        = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [LEN_W-1:0]   MAX_LEN_RST = '1;

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef logic [7:0] byte_t;
    typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

    // string literals are right-justified, so byte i of an entry holds the
    // character that must sit at window position i (newest byte at 0)
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_BITS'("union"),  KW_BITS'("select"),  KW_BITS'("insert"),
        KW_BITS'("update"), KW_BITS'("delete"),  KW_BITS'("drop"),
        KW_BITS'("create"), KW_BITS'("alter"),   KW_BITS'("exec"),
        KW_BITS'("execute"), KW_BITS'("script"), KW_BITS'("javascript"),
        KW_BITS'("onerror"), KW_BITS'("onload")
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        KW_LEN_W'(5), KW_LEN_W'(6), KW_LEN_W'(6), KW_LEN_W'(6),
        KW_LEN_W'(6), KW_LEN_W'(4), KW_LEN_W'(6), KW_LEN_W'(5),
        KW_LEN_W'(4), KW_LEN_W'(7), KW_LEN_W'(6), KW_LEN_W'(10),
        KW_LEN_W'(7), KW_LEN_W'(6)
    };

    typedef struct packed {
        logic  valid;
        logic  last;
        byte_t data;
    } item_t;

    typedef struct packed {
        logic valid;
        logic suspicious;
    } result_t;

    function automatic logic is_letter(input byte_t c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_alnum(input byte_t c);
        return is_letter(c) || (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input byte_t c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    function automatic byte_t to_lower(input byte_t c);
        return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sqlkw_kw_match.sv
// ----------------------------------------------------------------------------
// sqlkw_kw_match
// Parallel compare of all keywords against the newest bytes of a window,
// including the word-edge check in front of each keyword.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlkw_kw_match (
    input  wire sqlkw_pkg::window_t            window,
    input  wire logic [sqlkw_pkg::COUNT_W-1:0] avail,
    output logic                               hit
);

    logic kw_ok;

    always_comb
    begin
        hit   = 1'b0;
        kw_ok = 1'b0;
        for (int k = 0; k < sqlkw_pkg::KW_COUNT; k++)
        begin
            kw_ok = (avail >= sqlkw_pkg::COUNT_W'(sqlkw_pkg::KW_LEN[k]));
            for (int i = 0; i <= sqlkw_pkg::KW_MAXLEN; i++)
            begin
                if (i < int'(sqlkw_pkg::KW_LEN[k]))
                begin
                    if (sqlkw_pkg::to_lower(window[i]) != sqlkw_pkg::KW_TEXT[k][8*i +: 8])
                        kw_ok = 1'b0;
                end
                else if (i == int'(sqlkw_pkg::KW_LEN[k]))
                begin
                    // byte in front of the keyword must not extend the word
                    if (avail != sqlkw_pkg::COUNT_W'(sqlkw_pkg::KW_LEN[k]) &&
                        sqlkw_pkg::is_alnum(window[i]))
                        kw_ok = 1'b0;
                end
            end
            hit = hit | kw_ok;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sqlkw_core.sv
// ----------------------------------------------------------------------------
// sqlkw_core
// Per-statement scan state: byte window, byte count and pattern flags,
// updated once per byte; emits the verdict at the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlkw_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sqlkw_pkg::item_t            item,
    input  wire logic [sqlkw_pkg::LEN_W-1:0] max_length,
    output sqlkw_pkg::result_t               res
);

    sqlkw_pkg::window_t                window_reg, window_next, shifted;
    logic [sqlkw_pkg::COUNT_W-1:0]     count_reg, count_next, total;
    logic                              dash_reg, dash_next;
    logic                              semi_reg, semi_next;
    logic                              hit_reg, hit_next;
    logic                              hit_prev, hit_end;
    logic                              hit_item;
    sqlkw_pkg::byte_t                  c;

    assign c       = item.data;
    assign shifted = {window_reg[sqlkw_pkg::WINDOW_DEPTH-2:0], c};
    assign total   = (count_reg < sqlkw_pkg::COUNT_MAX) ? count_reg + 1'b1
                                                        : sqlkw_pkg::COUNT_MAX;

    // keyword ending at the previous byte, and keyword ending at this byte
    sqlkw_kw_match u_match_prev (
        .window (window_reg),
        .avail  (count_reg),
        .hit    (hit_prev)
    );

    sqlkw_kw_match u_match_end (
        .window (shifted),
        .avail  (total),
        .hit    (hit_end)
    );

    always_comb
    begin
        hit_item = hit_reg;
        dash_next = dash_reg;
        semi_next = semi_reg;

        if (count_reg == '0 && c == sqlkw_pkg::CH_DASH)
            dash_next = 1'b1;
        if (count_reg == sqlkw_pkg::COUNT_W'(1) && dash_reg && c == sqlkw_pkg::CH_DASH)
            hit_item = 1'b1;

        if (semi_reg)
        begin
            if (sqlkw_pkg::is_letter(c))
            begin
                hit_item  = 1'b1;
                semi_next = 1'b0;
            end
            else if (!sqlkw_pkg::is_space(c))
                semi_next = (c == sqlkw_pkg::CH_SEMI);
        end
        else if (c == sqlkw_pkg::CH_SEMI)
            semi_next = 1'b1;

        if (!sqlkw_pkg::is_alnum(c) && hit_prev)
            hit_item = 1'b1;

        res.valid      = 1'b0;
        res.suspicious = (hit_item || hit_end) && (total <= {1'b0, max_length});

        window_next = window_reg;
        count_next  = count_reg;
        hit_next    = hit_reg;
        if (!item.valid)
        begin
            dash_next = dash_reg;
            semi_next = semi_reg;
        end
        else if (!item.last)
        begin
            window_next = shifted;
            count_next  = total;
            hit_next    = hit_item;
        end
        else
        begin
            // statement ends: report and start clean
            res.valid   = 1'b1;
            window_next = '0;
            count_next  = '0;
            dash_next   = 1'b0;
            semi_next   = 1'b0;
            hit_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            dash_reg   <= 1'b0;
            semi_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
            dash_reg   <= dash_next;
            semi_reg   <= semi_next;
            hit_reg    <= hit_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sql_injection_keyword_scan.sv
// ----------------------------------------------------------------------------
// sql_injection_keyword_scan
// Flags statements that start with "--", hold ';' then a letter, or contain
// one of the fixed keywords as a whole word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one statement byte per transaction in tdata, tlast marks
//   the final byte. m_axis carries one verdict per statement, sent for the
//   transaction that had tlast set; tdata bit 0 is the suspicious flag.
//   cfg_we / cfg_wdata load max_length; statements longer than it report 0.
//   Write it only while no statement is in flight.
//   Path: the last byte passes the input register, then scan logic into
//   the result register. Throughput: one byte per cycle, except while a
//   last byte waits on a stalled m_axis; all keyword compares run in
//   parallel over an 11-byte window in the scan stage.
//   Reset clears the scan state and the registers and sets max_length to
//   65535. When the receiver stalls, the pending verdict holds; bytes that
//   are not last keep flowing, and a last byte waits in the input register
//   until the verdict register frees up, which drops s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_injection_keyword_scan (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] suspicious, [7:1] zero
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata       // max_length
);

    logic                            s1_valid_reg;
    logic                            s1_last_reg;
    sqlkw_pkg::byte_t                s1_data_reg;
    logic                            s1_go;
    logic [sqlkw_pkg::LEN_W-1:0]     max_len_reg;
    logic                            out_valid_reg;
    logic                            out_susp_reg;
    sqlkw_pkg::item_t                item;
    sqlkw_pkg::result_t              res;

    // a byte without tlast yields no verdict, so only a last byte waits on m_axis
    assign s1_go         = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_go;

    assign item.valid = s1_go;
    assign item.last  = s1_last_reg;
    assign item.data  = s1_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= sqlkw_pkg::MAX_LEN_RST;
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_data_reg  <= '0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            s1_valid_reg <= 1'b1;
            s1_last_reg  <= s_axis_tlast;
            s1_data_reg  <= s_axis_tdata;
        end
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    sqlkw_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .max_length (max_len_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_susp_reg  <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
            out_susp_reg  <= res.suspicious;
        end
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_susp_reg};

    // a verdict never lands on an unconsumed one
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(out_valid_reg && !m_axis_tready))
        else $error("verdict overwrites a pending result");

    // verdicts come only from a last byte leaving the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (s1_valid_reg && s1_last_reg))
        else $error("verdict without a last byte");

    // a stalled last byte blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a last byte is stalled");

endmodule

`default_nettype wire
